>>> rtl/core/sfoa_pkg.sv
// Package for the swap frame owner allocator.
// Holds sizes, mode/status/op codes and the command and result word types.
// No dependencies.
package sfoa_pkg;

  localparam int NUM_FRAMES      = 64;
  localparam int WPF_LOG2        = 4;
  localparam int WORDS_PER_FRAME = 1 << WPF_LOG2;

  localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
  localparam int LEN_W   = 12;
  localparam int NEED_W  = LEN_W + 1 - WPF_LOG2;
  localparam int PID_W   = 8;
  localparam int QFR_W   = 8;
  localparam int IDX_W   = 6;
  localparam int FCNT_W  = 7;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_COUNT = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  localparam logic [2:0] OP_REPLY = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_COUNT = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [1:0]         status;
    logic [PID_W-1:0]   pid;
    logic [FRAME_W-1:0] need;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  frame_index;
    logic              frame_valid;
    logic [PID_W-1:0]  owner;
    logic [FCNT_W-1:0] free_count;
    logic              last;
  } res_t;

endpackage

>>> rtl/core/sfoa_front.sv
// Front end: accepts request words, classifies them into commands, and
// holds them in a two-entry command queue. Depends on sfoa_pkg.
module sfoa_front import sfoa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        mode,
  input  logic [PID_W-1:0]  pid,
  input  logic [LEN_W-1:0]  program_length,
  input  logic [QFR_W-1:0]  frame,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  cmd_t       cls;
  logic [LEN_W:0]  len_sum;
  logic [NEED_W-1:0] need_full;
  logic       acc;
  logic       deq;

  assign len_sum   = {1'b0, program_length} + (LEN_W+1)'(WORDS_PER_FRAME - 1);
  assign need_full = len_sum[LEN_W:WPF_LOG2];

  always_comb begin
    cls        = '0;
    cls.op     = OP_REPLY;
    cls.status = ST_OK;
    cls.pid    = pid;
    cls.need   = need_full[FRAME_W-1:0];
    cls.frame  = frame[FRAME_W-1:0];
    case (mode)
      MODE_ALLOC: begin
        if (32'(need_full) >= 32'(NUM_FRAMES)) begin
          cls.status = ST_TOO_LARGE;
        end else if (need_full != '0) begin
          cls.op = OP_ALLOC;
        end
      end
      MODE_FREE: begin
        if (pid != '0) cls.op = OP_FREE;
      end
      MODE_QUERY: begin
        if (32'(frame) < 32'(NUM_FRAMES)) cls.op = OP_QUERY;
      end
      MODE_COUNT: cls.op = OP_COUNT;
      default:    cls.op = OP_REPLY;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign acc       = push && !full;
  assign deq       = cmd_pop && cmd_valid;

  always_comb begin
    cnt_next = cnt;
    if (acc && !deq) cnt_next = cnt + 2'd1;
    else if (!acc && deq) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (acc) wp <= ~wp;
      if (deq) rp <= ~rp;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) q[wp] <= cls;
  end

endmodule

>>> rtl/core/sfoa_back.sv
// Back end: owner table memory, scan sequencer, free frame counter and a
// two-entry result queue. Depends on sfoa_pkg.
module sfoa_back import sfoa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic res_empty,
  input  logic res_pop,
  output res_t res_out
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_QRY  = 2'd2;

  logic [1:0]         st;
  logic [1:0]         st_next;
  logic [CNT_W-1:0]   free_cnt;
  logic [PID_W-1:0]   mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] vld;
  logic [PID_W-1:0]   rdata;
  logic               rvld;
  logic [FRAME_W-1:0] raddr;
  logic               more;
  logic               p_valid;
  logic [FRAME_W-1:0] p_addr;
  logic [PID_W-1:0]   cur_pid;
  logic [FRAME_W-1:0] remain;
  logic               is_alloc;

  logic [PID_W-1:0]   owner_p;
  logic               hit;
  logic               res_full;
  logic               blocked;
  logic               scan_adv;
  logic               scan_issue;
  logic               free_done;
  logic               alloc_done;
  logic               idle_go;
  logic               no_space;
  logic               idle_reply;
  logic               qry_start;
  logic               scan_start;
  logic               rd_en;
  logic [FRAME_W-1:0] rd_addr;
  logic               wr_en;
  logic [PID_W-1:0]   wr_data;
  logic               res_push;
  res_t               res_in;

  res_t       rq [2];
  logic       rq_wp;
  logic       rq_rp;
  logic [1:0] rq_cnt;
  logic       rq_deq;

  assign owner_p    = rvld ? rdata : '0;
  assign hit        = p_valid && (is_alloc ? (owner_p == '0) : (owner_p == cur_pid));
  assign res_full   = (rq_cnt == 2'd2);
  assign blocked    = hit && is_alloc && res_full;
  assign scan_adv   = (st == S_SCAN) && !blocked;
  assign scan_issue = scan_adv && more;
  assign free_done  = (st == S_SCAN) && !is_alloc && !more && !p_valid;
  assign alloc_done = scan_adv && hit && is_alloc && (remain == FRAME_W'(1));
  assign idle_go    = (st == S_IDLE) && cmd_valid;
  assign no_space   = free_cnt < CNT_W'(cmd.need);
  assign idle_reply = idle_go && ((cmd.op == OP_REPLY) || (cmd.op == OP_COUNT) ||
                                  ((cmd.op == OP_ALLOC) && no_space));
  assign cmd_pop    = idle_go && (!idle_reply || !res_full);
  assign qry_start  = cmd_pop && (cmd.op == OP_QUERY);
  assign scan_start = cmd_pop && (((cmd.op == OP_ALLOC) && !no_space) ||
                                  (cmd.op == OP_FREE));
  assign rd_en      = qry_start || scan_issue;
  assign rd_addr    = qry_start ? cmd.frame : raddr;
  assign wr_en      = scan_adv && hit;
  assign wr_data    = is_alloc ? cur_pid : '0;

  always_comb begin
    res_push = 1'b0;
    res_in   = '0;
    res_in.last = 1'b1;
    if (idle_reply && cmd_pop) begin
      res_push = 1'b1;
      res_in.status = (cmd.op == OP_ALLOC) ? ST_NO_SPACE : cmd.status;
      if (cmd.op == OP_COUNT) res_in.free_count = FCNT_W'(free_cnt);
    end else if (scan_adv && hit && is_alloc) begin
      res_push = 1'b1;
      res_in.frame_index = IDX_W'(p_addr);
      res_in.frame_valid = 1'b1;
      res_in.owner       = cur_pid;
      res_in.last        = (remain == FRAME_W'(1));
    end else if (free_done && !res_full) begin
      res_push = 1'b1;
    end else if ((st == S_QRY) && !res_full) begin
      res_push = 1'b1;
      res_in.owner = owner_p;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (qry_start) st_next = S_QRY;
        else if (scan_start) st_next = S_SCAN;
      end
      S_SCAN: begin
        if (alloc_done || (free_done && !res_full)) st_next = S_IDLE;
      end
      S_QRY: begin
        if (!res_full) st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      free_cnt <= CNT_W'(NUM_FRAMES);
      vld      <= '0;
      p_valid  <= 1'b0;
      more     <= 1'b0;
    end else begin
      st <= st_next;
      if (scan_start) begin
        p_valid <= 1'b0;
        more    <= 1'b1;
      end else if (scan_adv) begin
        p_valid <= more;
        if (more) more <= (raddr != FRAME_W'(NUM_FRAMES - 1));
      end
      if (wr_en) begin
        vld[p_addr] <= 1'b1;
        if (!is_alloc) free_cnt <= free_cnt + CNT_W'(1);
        else if (cur_pid != '0) free_cnt <= free_cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      raddr    <= '0;
      cur_pid  <= cmd.pid;
      remain   <= cmd.need;
      is_alloc <= (cmd.op == OP_ALLOC);
    end else if (scan_adv) begin
      p_addr <= raddr;
      if (more) raddr <= raddr + FRAME_W'(1);
      if (hit && is_alloc) remain <= remain - FRAME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[p_addr] <= wr_data;
    if (rd_en) begin
      rdata <= mem[rd_addr];
      rvld  <= vld[rd_addr];
    end
  end

  // result queue
  assign res_empty = (rq_cnt == 2'd0);
  assign res_out   = rq[rq_rp];
  assign rq_deq    = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wp  <= 1'b0;
      rq_rp  <= 1'b0;
      rq_cnt <= 2'd0;
    end else begin
      if (res_push) rq_wp <= ~rq_wp;
      if (rq_deq) rq_rp <= ~rq_rp;
      if (res_push && !rq_deq) rq_cnt <= rq_cnt + 2'd1;
      else if (!res_push && rq_deq) rq_cnt <= rq_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) rq[rq_wp] <= res_in;
  end

  a_free_cnt_range: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= CNT_W'(NUM_FRAMES))
    else $error("free frame count out of range");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overrun");

  a_alloc_remain: assert property (@(posedge clk) disable iff (rst)
    (st == S_SCAN && is_alloc) |-> (remain != '0))
    else $error("allocation scan with nothing left to grant");

  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_SCAN && is_alloc && !more && !p_valid) |-> 1'b0)
    else $error("allocation scan ran past the table");

  a_query_path: assert property (@(posedge clk) disable iff (rst)
    qry_start |=> (st == S_QRY))
    else $error("query did not enter read state");

endmodule

>>> rtl/core/swap_frame_owner_allocator_unit.sv
// Top level of the swap frame owner allocator.
// Instantiates sfoa_front and sfoa_back; depends on sfoa_pkg.
//
// Request words enter through push/full; result words leave through
// empty/pop. A request is taken when push is high and full is low; the
// oldest result sits on the result ports while empty is low and is taken
// when pop is high. Each request gives one result word, except a granted
// allocate, which gives one word per frame in ascending frame order; the
// final word of each request has last set.
// Count, free with pid zero, out-of-range query, oversized, zero-length
// and refused allocates answer from the idle state; query after a table read.
// Allocate walks the owner table from frame 0 through the table memory, which
// has one read and one write port, one entry per cycle unless a full result
// queue holds it, and stops at the last granted frame. A free with a nonzero
// pid always walks all NUM_FRAMES entries. Requests are worked one at a
// time; a two-word command queue takes new requests meanwhile. When results
// are not popped the two-word result queue fills; an allocate walk then holds
// at its next free frame and a free at its end until space frees up.
// Reset empties both queues and marks every frame free at once; no
// clearing pass is needed.
module swap_frame_owner_allocator_unit import sfoa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        mode,
  input  logic [PID_W-1:0]  pid,
  input  logic [LEN_W-1:0]  program_length,
  input  logic [QFR_W-1:0]  frame,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status,
  output logic [IDX_W-1:0]  frame_index,
  output logic              frame_valid,
  output logic [PID_W-1:0]  owner,
  output logic [FCNT_W-1:0] free_count,
  output logic              last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t res_out;

  sfoa_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .mode           (mode),
    .pid            (pid),
    .program_length (program_length),
    .frame          (frame),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  sfoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_empty (empty),
    .res_pop   (pop),
    .res_out   (res_out)
  );

  assign status      = res_out.status;
  assign frame_index = res_out.frame_index;
  assign frame_valid = res_out.frame_valid;
  assign owner       = res_out.owner;
  assign free_count  = res_out.free_count;
  assign last        = res_out.last;

endmodule
